// ===== sv/cle_pkg.sv =====
// Shared constants, types and codes for the circular list eliminator.
`default_nettype none
package cle_pkg;
	localparam int RING_SIZE_DEF   = 1024;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_VAL_W       = 64;
	localparam int DATA_W          = 32;
	localparam int STEPS_W         = 16;
	localparam int REM_W           = 11;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_FULL = 2'd1;
	localparam status_t ST_FEW  = 2'd2;
	localparam status_t ST_LATE = 2'd3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_ELIM = 1'b1;
endpackage
`default_nettype wire

// ===== sv/cle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/cle_mod.sv =====
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
`default_nettype none
module cle_mod #(
	parameter int DIVIDEND_W = 16,
	parameter int DIVISOR_W  = 11
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       done,
	output logic      [DIVISOR_W-1:0]  rem
);
	localparam int IDX_W = $clog2(DIVIDEND_W);

	logic                  busy_q;
	logic                  done_q;
	logic [IDX_W-1:0]      idx_q;
	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;

	// rem stays below the divisor, so the trial stays below twice it
	assign trial = {rem_q, num_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= IDX_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				if (idx_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIVIDEND_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= diff[DIVISOR_W-1:0];
			end else begin
				rem_q <= trial[DIVISOR_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

// ===== sv/circular_list_eliminator.sv =====
// Load: the value and links are written in LDA, LDB and LDC, then the result in FIN; refused items go straight to FIN.
// Eliminate: the serial remainder runs in MOD, then WALK follows (steps mod entries) links through the link memory,
// and RDB, RDA, WRB and WRA read and write the unlink before FIN.
// One item in flight; the next is taken once its result sits in the output register.
// Reset clears control state and counters; the memories are not cleared and
// only slots already written are ever read.
`default_nettype none
module circular_list_eliminator #(
	parameter int RING_SIZE   = cle_pkg::RING_SIZE_DEF,
	parameter int VALUE_WIDTH = cle_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                operation,
	input  wire logic signed [cle_pkg::DATA_W-1:0]   value,
	input  wire logic        [cle_pkg::STEPS_W-1:0]  steps,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed      [cle_pkg::DATA_W-1:0]   removed_value,
	output logic signed      [cle_pkg::DATA_W-1:0]   next_value,
	output logic             [cle_pkg::REM_W-1:0]    remaining,
	output cle_pkg::status_t                         status
);
	import cle_pkg::*;

	localparam int IW = $clog2(RING_SIZE);
	localparam int CW = $clog2(RING_SIZE + 1);
	localparam int LW = 2 * IW;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LDA  = 4'd1;
	localparam logic [3:0] S_LDB  = 4'd2;
	localparam logic [3:0] S_LDC  = 4'd3;
	localparam logic [3:0] S_MOD  = 4'd4;
	localparam logic [3:0] S_WALK = 4'd5;
	localparam logic [3:0] S_RDB  = 4'd6;
	localparam logic [3:0] S_RDA  = 4'd7;
	localparam logic [3:0] S_WRB  = 4'd8;
	localparam logic [3:0] S_WRA  = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic [3:0]             state_q;
	logic [CW-1:0]          count_q;
	logic [IW-1:0]          cur_q;
	logic                   started_q;
	logic [VALUE_WIDTH-1:0] cur_val_q;
	logic [VALUE_WIDTH-1:0] v_q;
	logic [VALUE_WIDTH-1:0] removed_q;
	logic [IW-1:0]          slot_q;
	status_t                status_q;
	logic [IW-1:0]          node_q;
	logic [IW-1:0]          walk_cnt_q;
	logic [IW-1:0]          dead_q;
	logic [IW-1:0]          after_q;
	logic [IW-1:0]          before_q;
	logic [IW-1:0]          bprev_q;
	logic [IW-1:0]          anext_q;
	logic                   out_valid_q;

	logic                   link_we;
	logic [IW-1:0]          link_waddr;
	logic [LW-1:0]          link_wdata;
	logic [IW-1:0]          link_raddr;
	logic [LW-1:0]          link_rdata;
	logic                   val_we;
	logic [IW-1:0]          val_waddr;
	logic [IW-1:0]          val_raddr;
	logic [VALUE_WIDTH-1:0] val_rdata;

	logic                   in_beat;
	logic                   mod_start;
	logic                   mod_done;
	logic [CW-1:0]          mod_rem;
	logic [IW-1:0]          rd_next;
	logic [IW-1:0]          rd_prev;
	logic                   out_free;
	logic [MAX_VAL_W-1:0]   val_in_ext;
	logic [MAX_VAL_W-1:0]   cur_val_ext;
	logic [MAX_VAL_W-1:0]   removed_ext;
	logic [31:0]            count_ext;

	assign in_ready    = (state_q == S_IDLE);
	assign in_beat     = in_valid && in_ready;
	assign mod_start   = in_beat && (operation == OP_ELIM) && (count_q >= CW'(2));
	assign rd_next     = link_rdata[LW-1:IW];
	assign rd_prev     = link_rdata[IW-1:0];
	assign out_free    = !out_valid_q || out_ready;
	assign val_in_ext  = {{(MAX_VAL_W - DATA_W){1'b0}}, value};
	assign cur_val_ext = MAX_VAL_W'(cur_val_q);
	assign removed_ext = MAX_VAL_W'(removed_q);
	assign count_ext   = 32'(count_q);

	cle_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(RING_SIZE)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (v_q),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	// each entry packs {next, prev}
	cle_ram #(.WIDTH(LW), .DEPTH(RING_SIZE)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	cle_mod #(.DIVIDEND_W(STEPS_W), .DIVISOR_W(CW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (steps),
		.divisor  (count_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_comb begin
		link_we    = 1'b0;
		link_waddr = slot_q;
		link_wdata = '0;
		link_raddr = node_q;
		val_we     = 1'b0;
		val_waddr  = slot_q;
		val_raddr  = dead_q;
		case (state_q)
			S_LDA: begin
				// new tail points back at the head
				val_we     = 1'b1;
				link_we    = 1'b1;
				link_wdata = {IW'(0), (slot_q == '0) ? IW'(0) : slot_q - 1'b1};
			end
			S_LDB: begin
				link_we    = (slot_q > IW'(1));
				link_waddr = slot_q - 1'b1;
				link_wdata = {slot_q, slot_q - IW'(2)};
			end
			S_LDC: begin
				// head's prev follows the tail
				link_we    = (slot_q != '0);
				link_waddr = '0;
				link_wdata = {IW'(1), slot_q};
			end
			S_MOD: begin
				link_raddr = cur_q;
			end
			S_WALK: begin
				link_raddr = rd_next;
			end
			S_RDB: begin
				link_raddr = before_q;
				val_raddr  = dead_q;
			end
			S_RDA: begin
				link_raddr = after_q;
				val_raddr  = after_q;
			end
			S_WRB: begin
				link_we    = 1'b1;
				link_waddr = before_q;
				link_wdata = {after_q, bprev_q};
			end
			S_WRA: begin
				// with two entries left the survivor links to itself
				link_we    = 1'b1;
				link_waddr = after_q;
				link_wdata = (before_q == after_q) ? {after_q, before_q}
				                                   : {anext_q, before_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cur_q       <= '0;
			started_q   <= 1'b0;
			cur_val_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						if (operation == OP_LOAD) begin
							if (started_q || count_q == CW'(RING_SIZE)) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_LDA;
							end
						end else if (count_q < CW'(2)) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_LDA: begin
					count_q <= count_q + 1'b1;
					if (slot_q == '0) begin
						cur_val_q <= v_q;
					end
					state_q <= S_LDB;
				end
				S_LDB: state_q <= S_LDC;
				S_LDC: state_q <= S_FIN;
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (walk_cnt_q == '0) begin
						state_q <= S_RDB;
					end
				end
				S_RDB: state_q <= S_RDA;
				S_RDA: state_q <= S_WRB;
				S_WRB: begin
					cur_val_q <= val_rdata;
					state_q   <= S_WRA;
				end
				S_WRA: begin
					cur_q     <= after_q;
					count_q   <= count_q - 1'b1;
					started_q <= 1'b1;
					state_q   <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_beat) begin
					v_q       <= val_in_ext[VALUE_WIDTH-1:0];
					slot_q    <= count_q[IW-1:0];
					removed_q <= '0;
					if (operation == OP_LOAD) begin
						if (started_q) begin
							status_q <= ST_LATE;
						end else if (count_q == CW'(RING_SIZE)) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_OK;
						end
					end else if (count_q < CW'(2)) begin
						status_q <= ST_FEW;
					end else begin
						status_q <= ST_OK;
					end
				end
			end
			S_MOD: begin
				node_q     <= cur_q;
				walk_cnt_q <= mod_rem[IW-1:0];
			end
			S_WALK: begin
				if (walk_cnt_q == '0) begin
					dead_q   <= node_q;
					after_q  <= rd_next;
					before_q <= rd_prev;
				end else begin
					node_q     <= rd_next;
					walk_cnt_q <= walk_cnt_q - 1'b1;
				end
			end
			S_RDA: begin
				bprev_q   <= rd_prev;
				removed_q <= val_rdata;
			end
			S_WRB: begin
				anext_q <= rd_next;
			end
			S_FIN: begin
				if (out_free) begin
					removed_value <= removed_ext[DATA_W-1:0];
					next_value    <= cur_val_ext[DATA_W-1:0];
					remaining     <= count_ext[REM_W-1:0];
					status        <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// ===== sv/cle_checker.sv =====
// Port-level checks for the circular list eliminator, bound to the top level.
`default_nettype none
module cle_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic signed [cle_pkg::DATA_W-1:0] removed_value,
	input wire logic signed [cle_pkg::DATA_W-1:0] next_value,
	input wire logic        [cle_pkg::REM_W-1:0]  remaining,
	input wire cle_pkg::status_t                  status
);
	import cle_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(removed_value)
			&& $stable(next_value) && $stable(remaining) && $stable(status))
		else $error("result beat changed while stalled");

	// only one item in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FEW || status == ST_FULL || status == ST_LATE)
			|-> removed_value == '0)
		else $error("refused item reports a removed value");

	a_few_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FEW |-> remaining < REM_W'(2))
		else $error("too-few status with two or more entries");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && remaining == '0 |-> next_value == '0)
		else $error("empty ring reports a current value");
endmodule

bind circular_list_eliminator cle_checker u_cle_checker (.*);
`default_nettype wire
